// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level module that checks this block.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle in which the condition holds.
`define CHK_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// The property must hold in the cycle after the condition holds.
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/clfp_pkg.sv -----
package clfp_pkg;

	localparam int NODES      = 16;
	localparam int NAME_CHARS = 8;

	localparam int IDX_W  = $clog2(NODES);
	localparam int LINK_W = IDX_W + 1;
	localparam int ID_W   = 31;
	localparam int TEXT_W = 64;
	localparam int SEX_W  = 8;
	localparam int SLOT_W = 4;
	localparam int TEXT_BYTES = TEXT_W / 8;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;

	// All ones never names a node.
	localparam link_t LINK_NULL = '1;

	// Packed so that the identifier sits in the lowest bits.
	typedef struct packed {
		logic [TEXT_W-1:0] prog;
		logic [SEX_W-1:0]  sex;
		logic [TEXT_W-1:0] name;
		logic [ID_W-1:0]   id;
	} rec_t;

	localparam int REC_W      = $bits(rec_t);
	localparam int IN_DATA_W  = ((REC_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((REC_W + SLOT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_REMOVED   = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic load_in;
		logic ins_read;
		logic ins_write;
		logic set_full;
		logic rm_start;
		logic rm_next;
		logic rm_hit;
		logic rm_free;
		logic set_not_found;
		logic load_out;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic free_null;
		logic list_null;
		logic hit;
		logic walk_end;
		logic out_busy;
	} sts_t;

	function automatic logic link_ok(input link_t l);
		return l < LINK_W'(NODES);
	endfunction

	// Keeps the bytes before the first zero byte, at most NAME_CHARS of them.
	function automatic logic [TEXT_W-1:0] cut_text(input logic [TEXT_W-1:0] v);
		logic [TEXT_W-1:0] r;
		logic              live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < TEXT_BYTES; i++) begin
			if (i >= NAME_CHARS || v[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				r[8*i +: 8] = v[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

// ----- src/clfp_ctrl.sv -----
module clfp_ctrl
	import clfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_mode,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_RD   = 7'b0000010,
		S_INS_WR   = 7'b0000100,
		S_RM_START = 7'b0001000,
		S_RM_CMP   = 7'b0010000,
		S_RM_FREE  = 7'b0100000,
		S_FIN      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = (in_mode == MODE_REMOVE) ? S_RM_START : S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (sts.free_null) begin
					cmd.set_full = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.ins_read = 1'b1;
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.ins_write = 1'b1;
				state_d = S_FIN;
			end
			S_RM_START: begin
				if (sts.list_null) begin
					cmd.set_not_found = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.rm_start = 1'b1;
					state_d = S_RM_CMP;
				end
			end
			S_RM_CMP: begin
				if (sts.hit) begin
					cmd.rm_hit = 1'b1;
					state_d = S_RM_FREE;
				end else if (sts.walk_end) begin
					cmd.set_not_found = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.rm_next = 1'b1;
				end
			end
			S_RM_FREE: begin
				cmd.rm_free = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/clfp_dp.sv -----
module clfp_dp
	import clfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  rec_t              in_rec,
	output logic              out_valid,
	input  logic              out_ready,
	output status_t           out_status,
	output logic [SLOT_W-1:0] out_slot,
	output rec_t              out_rec
);

	// Node store: records and links in two arrays sharing one read address.
	rec_t  rec_mem [NODES];
	link_t lnk_mem [NODES];
	logic [NODES-1:0] rec_vld_q;
	logic [NODES-1:0] lnk_vld_q;

	rec_t  rec_in_q;
	link_t free_head_q, list_head_q, prev_q;
	idx_t  cur_q;
	idx_t  steps_q;

	rec_t  rd_rec_q;
	link_t rd_lnk_q;
	logic  rd_rec_ok_q, rd_lnk_ok_q;
	idx_t  rd_addr_q;

	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	rec_t              res_rec_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	rec_t              out_rec_q;

	logic  rd_en;
	idx_t  rd_addr;
	rec_t  rd_rec;
	link_t rd_link;
	link_t rd_dflt;

	logic  rec_we, lnk_we;
	idx_t  rec_wa, lnk_wa;
	rec_t  rec_wd;
	link_t lnk_wd;

	// An entry never written reads as its reset value.
	assign rd_dflt = (rd_addr_q == '0) ? LINK_NULL : ({1'b0, rd_addr_q} - LINK_W'(1));
	assign rd_rec  = rd_rec_ok_q ? rd_rec_q : '0;
	assign rd_link = rd_lnk_ok_q ? rd_lnk_q : rd_dflt;

	assign rd_en = cmd.ins_read | cmd.rm_start | cmd.rm_next;

	always_comb begin
		if (cmd.ins_read) begin
			rd_addr = free_head_q[IDX_W-1:0];
		end else if (cmd.rm_start) begin
			rd_addr = list_head_q[IDX_W-1:0];
		end else begin
			rd_addr = rd_link[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_rec_q    <= rec_mem[rd_addr];
			rd_lnk_q    <= lnk_mem[rd_addr];
			rd_rec_ok_q <= rec_vld_q[rd_addr];
			rd_lnk_ok_q <= lnk_vld_q[rd_addr];
			rd_addr_q   <= rd_addr;
		end
	end

	always_comb begin
		rec_we = 1'b0;
		rec_wa = cur_q;
		rec_wd = '0;
		lnk_we = 1'b0;
		lnk_wa = cur_q;
		lnk_wd = free_head_q;
		if (cmd.ins_write) begin
			rec_we = 1'b1;
			rec_wa = free_head_q[IDX_W-1:0];
			rec_wd = rec_in_q;
			lnk_we = 1'b1;
			lnk_wa = free_head_q[IDX_W-1:0];
			lnk_wd = list_head_q;
		end else if (cmd.rm_hit) begin
			rec_we = 1'b1;
			lnk_we = link_ok(prev_q);
			lnk_wa = prev_q[IDX_W-1:0];
			lnk_wd = rd_link;
		end else if (cmd.rm_free) begin
			lnk_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= '0;
			lnk_vld_q <= '0;
		end else begin
			if (rec_we) begin
				rec_vld_q[rec_wa] <= 1'b1;
			end
			if (lnk_we) begin
				lnk_vld_q[lnk_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= LINK_W'(NODES - 1);
			list_head_q <= LINK_NULL;
			cur_q       <= '0;
			prev_q      <= LINK_NULL;
			steps_q     <= '0;
		end else begin
			if (cmd.ins_write) begin
				free_head_q <= rd_link;
				list_head_q <= free_head_q;
			end
			if (cmd.rm_start) begin
				cur_q   <= list_head_q[IDX_W-1:0];
				prev_q  <= LINK_NULL;
				steps_q <= '0;
			end
			if (cmd.rm_next) begin
				prev_q  <= {1'b0, cur_q};
				cur_q   <= rd_link[IDX_W-1:0];
				steps_q <= steps_q + IDX_W'(1);
			end
			if (cmd.rm_hit && !link_ok(prev_q)) begin
				list_head_q <= rd_link;
			end
			if (cmd.rm_free) begin
				free_head_q <= {1'b0, cur_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rec_in_q.id   <= in_rec.id;
			rec_in_q.name <= cut_text(in_rec.name);
			rec_in_q.sex  <= in_rec.sex;
			rec_in_q.prog <= cut_text(in_rec.prog);
		end
		if (cmd.ins_write) begin
			res_status_q <= STAT_INSERTED;
			res_slot_q   <= SLOT_W'(free_head_q[IDX_W-1:0]);
			res_rec_q    <= '0;
		end
		if (cmd.set_full) begin
			res_status_q <= STAT_FULL;
			res_slot_q   <= '0;
			res_rec_q    <= '0;
		end
		if (cmd.set_not_found) begin
			res_status_q <= STAT_NOT_FOUND;
			res_slot_q   <= '0;
			res_rec_q    <= '0;
		end
		if (cmd.rm_hit) begin
			res_status_q <= STAT_REMOVED;
			res_slot_q   <= SLOT_W'(cur_q);
			res_rec_q    <= rd_rec;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_rec_q    <= res_rec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.free_null = !link_ok(free_head_q);
	assign sts.list_null = !link_ok(list_head_q);
	assign sts.hit       = (rd_rec.name == rec_in_q.name);
	assign sts.walk_end  = !link_ok(rd_link) || (steps_q == IDX_W'(NODES - 1));
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_rec    = out_rec_q;

endmodule

// ----- src/cursor_list_free_pool.sv -----
// Record pool of NODES nodes kept as one singly linked list, with the unused
// nodes chained on a free list through the same link field. A transfer with
// tuser low inserts the record at the front of the list, taking the node at
// the head of the free list, and reports pool full when none is left. A
// transfer with tuser high removes the first node whose name equals the given
// name, returns its record and pushes the cleared node back on the free list,
// or reports not found. Names and programs are cut at their first zero byte
// and at NAME_CHARS bytes before they are stored or compared. One item is
// handled at a time. An insert reads the node at the head of the free list
// and then writes the record into it, while a pool-full insert goes straight
// to its result. A remove walks the list one node per cycle through the node
// store's single registered read port, examining at most NODES nodes, and on
// a match clears the node and then pushes it on the free list. The next input
// transfer can be taken once the result is in the output register, even if
// that result has not yet been taken. Reset takes effect at once; per-node
// valid flags supply the reset contents, so there is no clearing pass.
`include "assert_macros.svh"

module cursor_list_free_pool
	import clfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// record_id, record_name, record_sex, record_program, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// slot, out_id, out_name, out_sex, out_program, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [1:0]            m_axis_tuser
);

	cmd_t              cmd;
	sts_t              sts;
	rec_t              in_rec;
	status_t           out_status;
	logic [SLOT_W-1:0] out_slot;
	rec_t              out_rec;
	logic [2:0]        rd_cmds;

	// The record fields sit in tdata in the order of the packed record type.
	assign in_rec = rec_t'(s_axis_tdata[REC_W-1:0]);

	clfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	clfp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_rec     (in_rec),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_slot   (out_slot),
		.out_rec    (out_rec)
	);

	assign m_axis_tdata = {(OUT_DATA_W - REC_W - SLOT_W)'(0), out_rec, out_slot};
	assign m_axis_tuser = out_status;

	// The node store has one read port, so at most one read is issued a cycle.
	assign rd_cmds = {cmd.ins_read, cmd.rm_start, cmd.rm_next};

	`CHK_NEXT(a_accept_then_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")
	`CHK_IMPLY(a_load_out_free, cmd.load_out, !sts.out_busy, "result loaded over a waiting result")
	`CHK_IMPLY(a_one_read, 1'b1, $onehot0(rd_cmds), "more than one node store read in a cycle")
	`CHK_NEXT(a_hit_then_free, cmd.rm_hit, cmd.rm_free, "removed node not pushed on the free list")

endmodule
